@@ hw/rtl/fpsa_pkg.sv @@
`timescale 1ns / 1ps
package fpsa_pkg;

  localparam int NFS = 16;
  localparam int NAT = 32;
  localparam int OFFSET_BITS = 20;
  localparam int FS_IW = $clog2(NFS);
  localparam int AT_IW = $clog2(NAT);
  localparam int IDX_W = AT_IW + 1;
  localparam int CNT_W = FS_IW + 1;
  localparam int LEN_W = 21;
  localparam int ADDR_W = 32;

  localparam logic [LEN_W-1:0] HEAP_MAX =
    ((1 << OFFSET_BITS) < 1048576) ? LEN_W'(1 << OFFSET_BITS) : LEN_W'(1048576);

  localparam logic [1:0] REQ_FIRST = 2'd0;
  localparam logic [1:0] REQ_BEST  = 2'd1;
  localparam logic [1:0] REQ_WORST = 2'd2;
  localparam logic [1:0] REQ_FREE  = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_DISABLED = 3'd1;
  localparam logic [2:0] ST_NO_FIT   = 3'd2;
  localparam logic [2:0] ST_NOT_LIVE = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  localparam logic [1:0] CFG_BASE   = 2'd0;
  localparam logic [1:0] CFG_SIZE   = 2'd1;
  localparam logic [1:0] CFG_ENABLE = 2'd2;

  typedef struct packed {
    logic [LEN_W-1:0] off;
    logic [LEN_W-1:0] len;
  } seg_t;

  typedef struct packed {
    logic             ok;
    logic [AT_IW-1:0] slot;
  } slot_t;

endpackage

@@ hw/rtl/fpsa_ram.sv @@
`timescale 1ns / 1ps
module fpsa_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 42
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/fpsa_slot_find.sv @@
`timescale 1ns / 1ps
module fpsa_slot_find (
  input  logic [fpsa_pkg::NAT-1:0] live,
  output fpsa_pkg::slot_t          slot
);

  always_comb begin
    slot.ok = 1'b0;
    slot.slot = '0;
    for (int i = fpsa_pkg::NAT - 1; i >= 0; i--) begin
      if (!live[i]) begin
        slot.ok = 1'b1;
        slot.slot = fpsa_pkg::AT_IW'(i);
      end
    end
  end

endmodule

@@ hw/rtl/fit_policy_segment_allocator.sv @@
`timescale 1ns / 1ps
// Heap allocator with first, best and worst fit and coalescing on free. One request is
// taken at a time; s_axis_tready is low until its result is loaded into the output
// register. An allocation scans the free segments and moves the segments behind one
// that empties; a free looks up the address in the allocation slots, scans the segments
// for the merge point and moves segments on insert or removal. The pace of all of it is
// set by the single read port of the segment and allocation memories, which the
// sequencer visits one entry per step. Writing heap_size re-initializes the tables.
module fit_policy_segment_allocator (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [55:0]  s_axis_tdata,  // req_size, free_address
  input  logic [1:0]   s_axis_tuser,  // req_type
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [111:0] m_axis_tdata,  // granted_address, allocated_bytes, free_bytes,
                                      // fragment_count, success_count
  output logic [2:0]   m_axis_tuser   // status
);

  localparam int LW = fpsa_pkg::LEN_W;
  localparam int IW = fpsa_pkg::IDX_W;
  localparam int FW = fpsa_pkg::FS_IW;
  localparam int AW = fpsa_pkg::AT_IW;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_A_RD   = 4'd1;
  localparam logic [3:0] S_A_CMP  = 4'd2;
  localparam logic [3:0] S_A_END  = 4'd3;
  localparam logic [3:0] S_F_RD   = 4'd4;
  localparam logic [3:0] S_F_CMP  = 4'd5;
  localparam logic [3:0] S_K_RD   = 4'd6;
  localparam logic [3:0] S_K_CMP  = 4'd7;
  localparam logic [3:0] S_MERGE  = 4'd8;
  localparam logic [3:0] S_MV_RD  = 4'd9;
  localparam logic [3:0] S_MV_WR  = 4'd10;
  localparam logic [3:0] S_INS_WR = 4'd11;
  localparam logic [3:0] S_DONE   = 4'd12;

  logic [3:0] state;
  logic [31:0] heap_base;
  logic [LW-1:0] heap_size;
  logic enabled;
  logic [fpsa_pkg::CNT_W-1:0] fs_count;
  logic [fpsa_pkg::NAT-1:0] live;
  logic [31:0] success;
  logic [LW-1:0] total;

  logic [1:0] rtype;
  logic [LW-1:0] rsize;
  logic [31:0] raddr;
  logic [2:0] status;
  logic [31:0] granted;
  logic [IW-1:0] idx;
  logic [IW-1:0] k;
  logic found;
  logic [FW-1:0] pick;
  fpsa_pkg::seg_t pick_seg;
  logic [AW-1:0] slot;
  fpsa_pkg::seg_t aseg;
  fpsa_pkg::seg_t prev;
  fpsa_pkg::seg_t cur;
  logic have_prev;
  logic have_cur;
  logic ins_mode;

  logic seg_we;
  logic [FW-1:0] seg_waddr;
  fpsa_pkg::seg_t seg_wdata;
  logic [FW-1:0] seg_raddr;
  fpsa_pkg::seg_t seg_rdata;
  logic at_we;
  logic [AW-1:0] at_raddr;
  fpsa_pkg::seg_t at_rdata;
  fpsa_pkg::slot_t free_slot;

  logic [LW-1:0] cfg_size;
  logic fit;
  logic better;
  logic joins_prev;
  logic after;
  logic [IW-1:0] fs_count_x;

  fpsa_ram #(.DEPTH(fpsa_pkg::NFS), .WIDTH(2 * LW)) u_seg_ram (
    .clk(clk), .we(seg_we), .waddr(seg_waddr), .wdata(seg_wdata),
    .raddr(seg_raddr), .rdata(seg_rdata)
  );

  fpsa_ram #(.DEPTH(fpsa_pkg::NAT), .WIDTH(2 * LW)) u_alloc_ram (
    .clk(clk), .we(at_we), .waddr(free_slot.slot), .wdata({pick_seg.off, rsize}),
    .raddr(at_raddr), .rdata(at_rdata)
  );

  fpsa_slot_find u_slot_find (.live(live), .slot(free_slot));

  assign s_axis_tready = (state == S_IDLE);
  assign fs_count_x = IW'(fs_count);
  assign cfg_size = (cfg_data[LW-1:0] > fpsa_pkg::HEAP_MAX) ? fpsa_pkg::HEAP_MAX
                                                             : cfg_data[LW-1:0];
  assign fit = (seg_rdata.len >= rsize);
  assign better = !found || (rtype == fpsa_pkg::REQ_BEST && seg_rdata.len < pick_seg.len)
                  || (rtype == fpsa_pkg::REQ_WORST && seg_rdata.len > pick_seg.len);
  assign joins_prev = have_prev && (prev.off + prev.len == aseg.off);
  assign after = have_cur && (cur.off == aseg.off + aseg.len);
  assign at_raddr = idx[AW-1:0];

  always_comb begin
    seg_raddr = idx[FW-1:0];
    if (state == S_MV_RD) begin
      seg_raddr = ins_mode ? FW'(idx - IW'(1)) : FW'(idx + IW'(1));
    end
  end

  always_comb begin
    seg_we = 1'b0;
    seg_waddr = '0;
    seg_wdata = '0;
    at_we = 1'b0;
    if (cfg_we && cfg_index == fpsa_pkg::CFG_SIZE) begin
      seg_we = 1'b1;
      seg_wdata.len = cfg_size;
    end else begin
      unique case (state)
        S_A_END: begin
          if (found && free_slot.ok) begin
            at_we = 1'b1;
            seg_we = 1'b1;
            seg_waddr = pick;
            seg_wdata.off = pick_seg.off + rsize;
            seg_wdata.len = pick_seg.len - rsize;
          end
        end
        S_MERGE: begin
          if (joins_prev) begin
            seg_we = 1'b1;
            seg_waddr = FW'(k - IW'(1));
            seg_wdata.off = prev.off;
            seg_wdata.len = after ? prev.len + aseg.len + cur.len : prev.len + aseg.len;
          end else if (after) begin
            seg_we = 1'b1;
            seg_waddr = k[FW-1:0];
            seg_wdata.off = aseg.off;
            seg_wdata.len = cur.len + aseg.len;
          end
        end
        S_MV_WR: begin
          seg_we = 1'b1;
          seg_waddr = idx[FW-1:0];
          seg_wdata = seg_rdata;
        end
        S_INS_WR: begin
          seg_we = 1'b1;
          seg_waddr = k[FW-1:0];
          seg_wdata = aseg;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      heap_base <= '0;
      heap_size <= '0;
      enabled <= 1'b0;
      fs_count <= '0;
      live <= '0;
      success <= '0;
      total <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && state != S_DONE) begin
        m_axis_tvalid <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          fpsa_pkg::CFG_BASE: heap_base <= cfg_data;
          fpsa_pkg::CFG_SIZE: begin
            heap_size <= cfg_size;
            fs_count <= (cfg_size != '0) ? fpsa_pkg::CNT_W'(1) : '0;
            live <= '0;
            success <= '0;
            total <= '0;
          end
          fpsa_pkg::CFG_ENABLE: enabled <= cfg_data[0];
          default: begin
          end
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            rtype <= s_axis_tuser;
            rsize <= s_axis_tdata[LW-1:0];
            raddr <= s_axis_tdata[LW+31:LW];
            granted <= '0;
            idx <= '0;
            found <= 1'b0;
            have_prev <= 1'b0;
            if (!enabled) begin
              status <= fpsa_pkg::ST_DISABLED;
              state <= S_DONE;
            end else if (s_axis_tuser == fpsa_pkg::REQ_FREE) begin
              state <= S_F_RD;
            end else if (s_axis_tdata[LW-1:0] == '0) begin
              status <= fpsa_pkg::ST_NO_FIT;
              state <= S_DONE;
            end else begin
              state <= S_A_RD;
            end
          end
        end
        S_A_RD: state <= (idx == fs_count_x) ? S_A_END : S_A_CMP;
        S_A_CMP: begin
          if (fit && better) begin
            found <= 1'b1;
            pick <= idx[FW-1:0];
            pick_seg <= seg_rdata;
          end
          if (fit && !found && rtype == fpsa_pkg::REQ_FIRST) begin
            state <= S_A_END;
          end else begin
            idx <= idx + IW'(1);
            state <= S_A_RD;
          end
        end
        S_A_END: begin
          if (!found) begin
            status <= fpsa_pkg::ST_NO_FIT;
            state <= S_DONE;
          end else if (!free_slot.ok) begin
            status <= fpsa_pkg::ST_FULL;
            state <= S_DONE;
          end else begin
            status <= fpsa_pkg::ST_OK;
            live[free_slot.slot] <= 1'b1;
            granted <= heap_base + 32'(pick_seg.off);
            success <= success + 32'd1;
            total <= total + rsize;
            if (pick_seg.len == rsize) begin
              idx <= IW'(pick);
              ins_mode <= 1'b0;
              state <= S_MV_RD;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_F_RD: begin
          if (idx == IW'(fpsa_pkg::NAT)) begin
            status <= fpsa_pkg::ST_NOT_LIVE;
            state <= S_DONE;
          end else if (!live[idx[AW-1:0]]) begin
            idx <= idx + IW'(1);
          end else begin
            state <= S_F_CMP;
          end
        end
        S_F_CMP: begin
          if (heap_base + 32'(at_rdata.off) == raddr) begin
            slot <= idx[AW-1:0];
            aseg <= at_rdata;
            idx <= '0;
            state <= S_K_RD;
          end else begin
            idx <= idx + IW'(1);
            state <= S_F_RD;
          end
        end
        S_K_RD: begin
          if (idx == fs_count_x) begin
            k <= idx;
            have_cur <= 1'b0;
            state <= S_MERGE;
          end else begin
            state <= S_K_CMP;
          end
        end
        S_K_CMP: begin
          if (seg_rdata.off < aseg.off) begin
            prev <= seg_rdata;
            have_prev <= 1'b1;
            idx <= idx + IW'(1);
            state <= S_K_RD;
          end else begin
            cur <= seg_rdata;
            have_cur <= 1'b1;
            k <= idx;
            state <= S_MERGE;
          end
        end
        S_MERGE: begin
          if (!joins_prev && !after && fs_count >= fpsa_pkg::CNT_W'(fpsa_pkg::NFS)) begin
            status <= fpsa_pkg::ST_FULL;
            state <= S_DONE;
          end else begin
            status <= fpsa_pkg::ST_OK;
            live[slot] <= 1'b0;
            total <= total - aseg.len;
            if (joins_prev && after) begin
              idx <= k;
              ins_mode <= 1'b0;
              state <= S_MV_RD;
            end else if (joins_prev || after) begin
              state <= S_DONE;
            end else begin
              idx <= fs_count_x;
              ins_mode <= 1'b1;
              state <= S_MV_RD;
            end
          end
        end
        S_MV_RD: begin
          if (ins_mode) begin
            state <= (idx == k) ? S_INS_WR : S_MV_WR;
          end else if (idx + IW'(1) >= fs_count_x) begin
            fs_count <= fs_count - fpsa_pkg::CNT_W'(1);
            state <= S_DONE;
          end else begin
            state <= S_MV_WR;
          end
        end
        S_MV_WR: begin
          idx <= ins_mode ? idx - IW'(1) : idx + IW'(1);
          state <= S_MV_RD;
        end
        S_INS_WR: begin
          fs_count <= fs_count + fpsa_pkg::CNT_W'(1);
          state <= S_DONE;
        end
        S_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tuser <= status;
            m_axis_tdata <= {1'b0, success, 5'(fs_count), heap_size - total, total,
                             (status == fpsa_pkg::ST_OK) ? granted : 32'd0};
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    fs_count <= fpsa_pkg::CNT_W'(fpsa_pkg::NFS))
    else $error("segment count overflow");
  a_total_fits: assert property (@(posedge clk) disable iff (rst)
    total <= heap_size)
    else $error("allocated bytes exceed heap");
  a_one_request: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while busy");
  a_empty_heap: assert property (@(posedge clk) disable iff (rst)
    heap_size == '0 |-> fs_count == '0)
    else $error("segment in empty heap");
`endif

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
  import fpsa_pkg::*;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] granted;
    logic [20:0] alloc_bytes;
    logic [20:0] free_bytes;
    logic [4:0]  frags;
    logic [31:0] successes;
  } outcome_t;

  logic         clk;
  logic         rst;
  logic         cfg_we;
  logic [1:0]   cfg_index;
  logic [31:0]  cfg_data;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [55:0]  s_axis_tdata;
  logic [1:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [111:0] m_axis_tdata;
  logic [2:0]   m_axis_tuser;

  fit_policy_segment_allocator i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  // heap shadow
  logic [31:0] base_q;
  logic [20:0] size_q;
  logic        enabled_q;
  logic [20:0] seg_off [NFS];
  logic [20:0] seg_len [NFS];
  int          seg_cnt;
  logic        slot_live [NAT];
  logic [20:0] slot_off [NAT];
  logic [20:0] slot_len [NAT];
  logic [31:0] grant_cnt;
  logic [20:0] live_bytes;
  logic [31:0] live_addrs [$];

  outcome_t    expected_q [$];
  int          errors;
  int          granted_total;
  int          results_seen;
  int          idle_cycles;
  bit          hold_off;
  int          hold_cycles;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  task automatic heap_clear();
    for (int i = 0; i < NAT; i++) begin
      slot_live[i] = 0;
      slot_off[i] = 0;
      slot_len[i] = 0;
    end
    seg_cnt = 0;
    if (size_q != 0) begin
      seg_off[0] = 0;
      seg_len[0] = size_q;
      seg_cnt = 1;
    end
    grant_cnt = 0;
    live_bytes = 0;
    live_addrs.delete();
  endtask

  task automatic seg_drop(int k);
    for (int j = k; j + 1 < seg_cnt; j++) begin
      seg_off[j] = seg_off[j+1];
      seg_len[j] = seg_len[j+1];
    end
    seg_cnt--;
  endtask

  task automatic heap_allocate(logic [1:0] policy, logic [20:0] sz,
                               output logic [2:0] st, output logic [31:0] addr);
    int pick;
    int slot;
    bit found;
    pick = 0;
    found = 0;
    slot = -1;
    addr = 0;
    if (sz == 0) begin
      st = ST_NO_FIT;
      return;
    end
    for (int i = 0; i < seg_cnt; i++) begin
      if (seg_len[i] < sz) continue;
      if (!found) begin
        pick = i;
        found = 1;
        if (policy == REQ_FIRST) break;
      end else if (policy == REQ_BEST && seg_len[i] < seg_len[pick]) begin
        pick = i;
      end else if (policy == REQ_WORST && seg_len[i] > seg_len[pick]) begin
        pick = i;
      end
    end
    if (!found) begin
      st = ST_NO_FIT;
      return;
    end
    for (int i = 0; i < NAT; i++) begin
      if (!slot_live[i]) begin
        slot = i;
        break;
      end
    end
    if (slot < 0) begin
      st = ST_FULL;
      return;
    end
    slot_live[slot] = 1;
    slot_off[slot] = seg_off[pick];
    slot_len[slot] = sz;
    addr = base_q + 32'(seg_off[pick]);
    seg_off[pick] += sz;
    seg_len[pick] -= sz;
    if (seg_len[pick] == 0) seg_drop(pick);
    grant_cnt++;
    live_bytes += sz;
    st = ST_OK;
  endtask

  task automatic heap_release(logic [31:0] addr, output logic [2:0] st);
    int slot;
    int k;
    bit lo_adj;
    bit hi_adj;
    logic [20:0] off;
    logic [20:0] len;
    slot = -1;
    for (int i = 0; i < NAT; i++) begin
      if (slot_live[i] && base_q + 32'(slot_off[i]) == addr) begin
        slot = i;
        break;
      end
    end
    if (slot < 0) begin
      st = ST_NOT_LIVE;
      return;
    end
    off = slot_off[slot];
    len = slot_len[slot];
    k = 0;
    while (k < seg_cnt && seg_off[k] < off) k++;
    lo_adj = k > 0 && (seg_off[k-1] + seg_len[k-1]) == off;
    hi_adj = k < seg_cnt && seg_off[k] == off + len;
    if (lo_adj && hi_adj) begin
      seg_len[k-1] += len + seg_len[k];
      seg_drop(k);
    end else if (lo_adj) begin
      seg_len[k-1] += len;
    end else if (hi_adj) begin
      seg_off[k] = off;
      seg_len[k] += len;
    end else begin
      if (seg_cnt >= NFS) begin
        st = ST_FULL;
        return;
      end
      for (int j = seg_cnt; j > k; j--) begin
        seg_off[j] = seg_off[j-1];
        seg_len[j] = seg_len[j-1];
      end
      seg_off[k] = off;
      seg_len[k] = len;
      seg_cnt++;
    end
    slot_live[slot] = 0;
    slot_off[slot] = 0;
    slot_len[slot] = 0;
    live_bytes -= len;
    st = ST_OK;
  endtask

  function automatic outcome_t heap_outcome(logic [2:0] st, logic [31:0] addr);
    outcome_t o;
    logic [20:0] sum;
    sum = 0;
    for (int i = 0; i < seg_cnt; i++) sum += seg_len[i];
    o.status = st;
    o.granted = (st == ST_OK) ? addr : 32'd0;
    o.alloc_bytes = live_bytes;
    o.free_bytes = sum;
    o.frags = 5'(seg_cnt);
    o.successes = grant_cnt;
    return o;
  endfunction

  task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
    logic [20:0] v;
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      CFG_BASE: base_q = val;
      CFG_SIZE: begin
        v = val[20:0];
        size_q = (v > HEAP_MAX) ? HEAP_MAX : v;
        heap_clear();
      end
      CFG_ENABLE: enabled_q = val[0];
      default: ;
    endcase
  endtask

  task automatic send_request(logic [1:0] kind, logic [20:0] sz, logic [31:0] addr);
    logic [2:0] st;
    logic [31:0] g;
    int gap;
    g = 0;
    if ($urandom_range(0, 3) == 0) begin
      gap = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
      repeat (gap) @(posedge clk);
    end
    @(posedge clk);
    s_axis_tvalid <= 1;
    s_axis_tuser <= kind;
    s_axis_tdata <= {3'b0, addr, sz};
    do @(posedge clk); while (!s_axis_tready);
    s_axis_tvalid <= 0;
    if (!enabled_q) begin
      st = ST_DISABLED;
    end else if (kind == REQ_FREE) begin
      st = ST_OK;
      heap_release(addr, st);
      if (st == ST_OK)
        foreach (live_addrs[i]) if (live_addrs[i] == addr) begin
          live_addrs.delete(i);
          break;
        end
    end else begin
      heap_allocate(kind, sz, st, g);
      if (st == ST_OK) begin
        live_addrs.push_back(g);
        granted_total++;
      end
    end
    expected_q.push_back(heap_outcome(st, g));
  endtask

  task automatic drain();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    outcome_t got;
    outcome_t exp_o;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[52:32], m_axis_tdata[73:53],
             m_axis_tdata[78:74], m_axis_tdata[110:79]};
      results_seen++;
      if (expected_q.size() == 0) begin
        $error("unexpected result");
        errors++;
      end else begin
        exp_o = expected_q.pop_front();
        if (got.status !== exp_o.status) begin
          $error("status exp %0d got %0d", exp_o.status, got.status); errors++;
        end
        if (got.granted !== exp_o.granted) begin
          $error("granted_address exp %h got %h", exp_o.granted, got.granted); errors++;
        end
        if (got.alloc_bytes !== exp_o.alloc_bytes) begin
          $error("allocated_bytes exp %0d got %0d", exp_o.alloc_bytes, got.alloc_bytes);
          errors++;
        end
        if (got.free_bytes !== exp_o.free_bytes) begin
          $error("free_bytes exp %0d got %0d", exp_o.free_bytes, got.free_bytes); errors++;
        end
        if (got.frags !== exp_o.frags) begin
          $error("fragment_count exp %0d got %0d", exp_o.frags, got.frags); errors++;
        end
        if (got.successes !== exp_o.successes) begin
          $error("success_count exp %0d got %0d", exp_o.successes, got.successes); errors++;
        end
      end
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1;
    end else if (hold_off) begin
      m_axis_tready <= 0;
    end else if ($urandom_range(0, 4) == 0) begin
      m_axis_tready <= ($urandom_range(0, 9) == 0) ? 1'b0 : ~m_axis_tready;
    end else begin
      m_axis_tready <= 1;
    end
  end

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      hold_off <= 1;
    end else begin
      hold_off <= 0;
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  function automatic logic [31:0] pick_free_addr();
    if (live_addrs.size() != 0 && $urandom_range(0, 9) != 0)
      return live_addrs[$urandom_range(0, live_addrs.size() - 1)];
    return $urandom_range(0, 3) == 0 ? $urandom() : base_q + $urandom_range(0, 4096);
  endfunction

  task automatic test_disabled();
    send_request(REQ_FIRST, 21'd16, 0);
    send_request(REQ_FREE, 0, 32'hffff_ffff);
    drain();
    cfg_write(CFG_BASE, 32'h1000_0000);
    cfg_write(CFG_SIZE, 32'd0);
    cfg_write(CFG_ENABLE, 32'd1);
    send_request(REQ_BEST, 21'd1, 0);
    drain();
  endtask

  task automatic test_directed();
    cfg_write(CFG_SIZE, 32'h001f_ffff);
    send_request(REQ_FIRST, 21'd0, 0);
    send_request(REQ_WORST, 21'h1f_ffff, 0);
    send_request(REQ_FIRST, 21'd100, 0);
    send_request(REQ_FIRST, 21'd200, 0);
    send_request(REQ_FIRST, 21'd300, 0);
    send_request(REQ_FREE, 0, 32'h1000_0064);
    send_request(REQ_BEST, 21'd50, 0);
    send_request(REQ_WORST, 21'd50, 0);
    send_request(REQ_FREE, 0, 32'h1000_0000);
    send_request(REQ_FREE, 0, 32'h1000_012c);
    send_request(REQ_FREE, 0, 32'h1234_5678);
    drain();
    cfg_write(CFG_BASE, 32'hffff_f000);
    send_request(REQ_FREE, 0, 32'hffff_f032);
    send_request(REQ_FIRST, 21'd1048576, 0);
    drain();
    cfg_write(CFG_ENABLE, 32'd0);
    send_request(REQ_FREE, 0, 32'hffff_f000);
    drain();
    cfg_write(CFG_ENABLE, 32'd1);
    send_request(REQ_FREE, 0, 32'hffff_f000);
    drain();
  endtask

  // fill both tables: many small grants, then free every other one
  task automatic test_tables_full();
    cfg_write(CFG_BASE, 32'h0);
    cfg_write(CFG_SIZE, 32'd4096);
    for (int i = 0; i < NAT + 1; i++) send_request(REQ_FIRST, 21'd8, 0);
    for (int i = 0; i < NAT; i += 2) send_request(REQ_FREE, 0, 32'(i * 8));
    send_request(REQ_FREE, 0, 32'd248);
    drain();
  endtask

  task automatic test_backpressure();
    hold_cycles = 600;
    for (int i = 0; i < 6; i++) send_request(2'($urandom_range(0, 2)), 21'd4, 0);
    drain();
  endtask

  task automatic test_random(int count);
    logic [1:0] k;
    for (int i = 0; i < count; i++) begin
      if (i % 300 == 0) begin
        drain();
        cfg_write(CFG_BASE, $urandom());
        cfg_write(CFG_SIZE, ($urandom_range(0, 7) == 0) ? $urandom() :
                  32'($urandom_range(64, 8192)));
        cfg_write(CFG_ENABLE, 32'($urandom_range(0, 7) != 0));
      end
      k = 2'($urandom_range(0, 3));
      if (k == REQ_FREE)
        send_request(k, 21'($urandom()), pick_free_addr());
      else
        send_request(k, ($urandom_range(0, 19) == 0) ? 21'($urandom()) :
                     21'($urandom_range(0, 400)), $urandom());
    end
    drain();
  endtask

  initial begin
    rst = 1;
    cfg_we = 0;
    cfg_index = 0;
    cfg_data = 0;
    s_axis_tvalid = 0;
    s_axis_tdata = 0;
    s_axis_tuser = 0;
    errors = 0;
    granted_total = 0;
    results_seen = 0;
    idle_cycles = 0;
    hold_off = 0;
    hold_cycles = 0;
    base_q = 0;
    size_q = 0;
    enabled_q = 0;
    heap_clear();
    repeat (2) @(posedge clk);
    rst <= 0;
    test_disabled();
    test_directed();
    test_tables_full();
    test_backpressure();
    test_random(1850);
    $display("tb_top: %0d requests checked, %0d grants, across policies and heap settings",
             results_seen, granted_total);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
